// ===== rtl/cecc_pkg.sv =====
package cecc_pkg;

   localparam int PERIOD_BITS_DEF = 16;
   localparam int CYCLE_BITS_DEF  = 32;

   // Commands from the sequencer to the datapath
   typedef enum logic [2:0] {
      OP_IDLE   = 3'd0,  // hold everything
      OP_LOAD   = 3'd1,  // latch the transaction, seed the first GCD
      OP_GSTEP  = 3'd2,  // one binary GCD step
      OP_G1END  = 3'd3,  // keep GCD of periods, seed GCD of LCM and period
      OP_G2END  = 3'd4,  // keep that GCD, seed divider and multiplier
      OP_DSTEP  = 3'd5,  // one restoring division step
      OP_MSTEP  = 3'd6,  // one shift-add multiply step
      OP_COMMIT = 3'd7   // update running state and result register
   } op_type;

   typedef struct packed {
      logic gcd_done;  // one GCD operand has reached zero
      logic is_zero;   // latched period is zero
      logic is_start;  // latched item opens a new task set
      logic lcm_sat;   // running LCM is saturated
   } stat_type;

endpackage

// ===== rtl/cecc_ctrl.sv =====
module cecc_ctrl #(
   parameter int PERIOD_BITS = cecc_pkg::PERIOD_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic               rsp_tready,
   input  cecc_pkg::stat_type stat,
   output cecc_pkg::op_type   op,
   output logic               in_ready,
   output logic               out_valid
);

   localparam int CntBits = $clog2(PERIOD_BITS);
   localparam logic [CntBits-1:0] CntLast = CntBits'(PERIOD_BITS - 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CHECK = 7'b0000010,
      S_GCD1  = 7'b0000100,
      S_GCD2  = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_MUL   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic                valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      op       = cecc_pkg::OP_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op       = cecc_pkg::OP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.is_zero || stat.is_start) begin
               state_in = S_DONE;
            end else begin
               state_in = S_GCD1;
            end
         end
         S_GCD1: begin
            if (stat.gcd_done) begin
               op       = cecc_pkg::OP_G1END;
               state_in = stat.lcm_sat ? S_DONE : S_GCD2;
            end else begin
               op = cecc_pkg::OP_GSTEP;
            end
         end
         S_GCD2: begin
            if (stat.gcd_done) begin
               op       = cecc_pkg::OP_G2END;
               cnt_in   = '0;
               state_in = S_DIV;
            end else begin
               op = cecc_pkg::OP_GSTEP;
            end
         end
         S_DIV: begin
            op = cecc_pkg::OP_DSTEP;
            if (cnt_ff == CntLast) begin
               cnt_in   = '0;
               state_in = S_MUL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_MUL: begin
            op = cecc_pkg::OP_MSTEP;
            if (cnt_ff == CntLast) begin
               cnt_in   = '0;
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (!valid_ff || rsp_tready) begin
               op       = cecc_pkg::OP_COMMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register valid: set on commit, drop once taken
   always_comb begin
      priority if (op == cecc_pkg::OP_COMMIT) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = valid_ff;

endmodule

// ===== rtl/cecc_dpath.sv =====
module cecc_dpath #(
   parameter int PERIOD_BITS = cecc_pkg::PERIOD_BITS_DEF,
   parameter int CYCLE_BITS  = cecc_pkg::CYCLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cecc_pkg::op_type       op,
   input  logic [PERIOD_BITS-1:0] period,
   input  logic                   first_task,
   output cecc_pkg::stat_type     stat,
   output logic [CYCLE_BITS-1:0]  major_cycle,
   output logic [PERIOD_BITS-1:0] minor_cycle,
   output logic                   overflow,
   output logic                   status
);

   localparam int P  = PERIOD_BITS;
   localparam int C  = CYCLE_BITS;
   localparam int W  = (P > C) ? P : C;
   localparam int KW = $clog2(W + 1);
   localparam int MW = C + P;
   localparam logic [C-1:0] CycMax = '1;

   // running state
   logic [C-1:0]  lcm_ff, lcm_in;
   logic [P-1:0]  gcd_ff, gcd_in;
   logic          sat_ff, sat_in;
   logic          started_ff, started_in;

   // working registers
   logic [P-1:0]  per_ff, per_in;
   logic          first_ff, first_in;
   logic [W-1:0]  x_ff, x_in, y_ff, y_in;
   logic [KW-1:0] k_ff, k_in;
   logic [P-1:0]  g_ff, g_in, lg_ff, lg_in;
   logic [P-1:0]  rem_ff, rem_in, quo_ff, quo_in;
   logic [MW-1:0] mcand_ff, mcand_in, acc_ff, acc_in;

   // result register
   logic [C-1:0]  maj_ff, maj_in;
   logic [P-1:0]  min_ff, min_in;
   logic          ovf_ff, ovf_in, sts_ff, sts_in;

   logic [W-1:0]  gcd_res;
   logic [P:0]    trial;
   logic          take;
   logic [P-1:0]  trial_rem;

   assign gcd_res   = W'((x_ff | y_ff) << k_ff);
   assign trial     = {rem_ff, quo_ff[P-1]};
   assign take      = (trial >= {1'b0, lg_ff});
   assign trial_rem = P'(trial - {1'b0, lg_ff});

   assign stat.gcd_done = (x_ff == '0) || (y_ff == '0);
   assign stat.is_zero  = (per_ff == '0);
   assign stat.is_start = first_ff || !started_ff;
   assign stat.lcm_sat  = sat_ff;

   always_comb begin
      per_in   = per_ff;
      first_in = first_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      k_in     = k_ff;
      g_in     = g_ff;
      lg_in    = lg_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      unique case (op)
         cecc_pkg::OP_LOAD: begin
            per_in   = period;
            first_in = first_task;
            x_in     = W'(gcd_ff);
            y_in     = W'(period);
            k_in     = '0;
         end
         cecc_pkg::OP_GSTEP: begin
            // binary GCD: strip common twos, then odd differences
            priority if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff >= y_ff) begin
               x_in = x_ff - y_ff;
            end else begin
               y_in = y_ff - x_ff;
            end
         end
         cecc_pkg::OP_G1END: begin
            g_in = gcd_res[P-1:0];
            x_in = W'(lcm_ff);
            y_in = W'(per_ff);
            k_in = '0;
         end
         cecc_pkg::OP_G2END: begin
            lg_in    = gcd_res[P-1:0];
            rem_in   = '0;
            quo_in   = per_ff;
            mcand_in = MW'(lcm_ff);
            acc_in   = '0;
         end
         cecc_pkg::OP_DSTEP: begin
            rem_in = take ? trial_rem : trial[P-1:0];
            quo_in = {quo_ff[P-2:0], take};
         end
         cecc_pkg::OP_MSTEP: begin
            if (quo_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in = mcand_ff << 1;
            quo_in   = quo_ff >> 1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      lcm_in     = lcm_ff;
      gcd_in     = gcd_ff;
      sat_in     = sat_ff;
      started_in = started_ff;
      sts_in     = 1'b0;
      if (op == cecc_pkg::OP_COMMIT) begin
         priority if (per_ff == '0) begin
            sts_in = 1'b1;
         end else if (first_ff || !started_ff) begin
            started_in = 1'b1;
            gcd_in     = per_ff;
            if (W'(per_ff) > W'(CycMax)) begin
               lcm_in = CycMax;
               sat_in = 1'b1;
            end else begin
               lcm_in = C'(per_ff);
               sat_in = 1'b0;
            end
         end else begin
            gcd_in = g_ff;
            if (!sat_ff) begin
               if (acc_ff[MW-1:C] != '0) begin
                  lcm_in = CycMax;
                  sat_in = 1'b1;
               end else begin
                  lcm_in = acc_ff[C-1:0];
               end
            end
         end
      end
      maj_in = (op == cecc_pkg::OP_COMMIT) ? lcm_in : maj_ff;
      min_in = (op == cecc_pkg::OP_COMMIT) ? gcd_in : min_ff;
      ovf_in = (op == cecc_pkg::OP_COMMIT) ? sat_in : ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcm_ff     <= '0;
         gcd_ff     <= '0;
         sat_ff     <= 1'b0;
         started_ff <= 1'b0;
      end else begin
         lcm_ff     <= lcm_in;
         gcd_ff     <= gcd_in;
         sat_ff     <= sat_in;
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      per_ff   <= per_in;
      first_ff <= first_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      k_ff     <= k_in;
      g_ff     <= g_in;
      lg_ff    <= lg_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
      maj_ff   <= maj_in;
      min_ff   <= min_in;
      ovf_ff   <= ovf_in;
      if (op == cecc_pkg::OP_COMMIT) begin
         sts_ff <= sts_in;
      end
   end

   assign major_cycle = maj_ff;
   assign minor_cycle = min_ff;
   assign overflow    = ovf_ff;
   assign status      = sts_ff;

endmodule

// ===== rtl/cyclic_executive_cycle_calc.sv =====
// Running major/minor cycle calculator for a cyclic executive. Each request
// transaction carries one task period; the block answers with one response
// transaction holding the running least common multiple of the periods of
// the current task set (major cycle, saturating at all ones with a sticky
// overflow flag) and their running greatest common divisor (minor cycle).
// A request with tuser set opens a new task set; a zero period is rejected
// with status 1 and leaves the running values untouched. One request is
// worked at a time. A zero period or a set start goes from load through the
// check state straight to commit. Any other period then runs the first GCD
// (running minor cycle and period), the second GCD (running major cycle and
// period) on the same shared binary GCD unit, the PERIOD_BITS-step
// restoring divider and the PERIOD_BITS-step shift-add multiplier, and then
// commits. Once the major cycle is saturated only the first GCD runs. A
// finished response waits in its output register; while that register is
// still full the next result is held, so a stalled receiver adds its stall
// cycles. A new request is taken as soon as the sequencer is back at idle.
module cyclic_executive_cycle_calc #(
   parameter int PERIOD_BITS = cecc_pkg::PERIOD_BITS_DEF,
   parameter int CYCLE_BITS  = cecc_pkg::CYCLE_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // period
   input  logic [((PERIOD_BITS+7)/8)*8-1:0]             req_tdata,
   // first_task
   input  logic [0:0]                                   req_tuser,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   // major_cycle, minor_cycle, zero padding
   output logic [((CYCLE_BITS+PERIOD_BITS+7)/8)*8-1:0]  rsp_tdata,
   // overflow, status
   output logic [1:0]                                   rsp_tuser
);

   localparam int RspBits = ((CYCLE_BITS + PERIOD_BITS + 7) / 8) * 8;

   cecc_pkg::op_type   op;
   cecc_pkg::stat_type stat;
   logic               req_fire;
   logic [CYCLE_BITS-1:0]  major_cycle;
   logic [PERIOD_BITS-1:0] minor_cycle;
   logic               overflow;
   logic               status;

   // a request transaction completes on valid and ready together
   assign req_fire = req_tvalid && req_tready;

   // sequencer: walks load, GCDs, divide, multiply and commit
   cecc_ctrl #(
      .PERIOD_BITS (PERIOD_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .op         (op),
      .in_ready   (req_tready),
      .out_valid  (rsp_tvalid)
   );

   // datapath: running state, GCD unit, divider, multiplier, result register
   cecc_dpath #(
      .PERIOD_BITS (PERIOD_BITS),
      .CYCLE_BITS  (CYCLE_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .period      (req_tdata[PERIOD_BITS-1:0]),
      .first_task  (req_tuser[0]),
      .stat        (stat),
      .major_cycle (major_cycle),
      .minor_cycle (minor_cycle),
      .overflow    (overflow),
      .status      (status)
   );

   // pack the response: major cycle lowest, then minor cycle, pad to bytes
   assign rsp_tdata = RspBits'({minor_cycle, major_cycle});
   assign rsp_tuser = {status, overflow};

endmodule

// ===== rtl/cecc_checker.sv =====
module cecc_checker #(
   parameter int PERIOD_BITS = cecc_pkg::PERIOD_BITS_DEF,
   parameter int CYCLE_BITS  = cecc_pkg::CYCLE_BITS_DEF
) (
   input logic                                         clock,
   input logic                                         reset,
   input logic                                         req_tvalid,
   input logic                                         req_tready,
   input logic                                         rsp_tvalid,
   input logic                                         rsp_tready,
   input logic [((CYCLE_BITS+PERIOD_BITS+7)/8)*8-1:0]  rsp_tdata,
   input logic [1:0]                                   rsp_tuser
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // one request at a time: busy right after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // an accepted period always leaves nonzero cycles
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |->
         rsp_tdata[CYCLE_BITS-1:0] != '0 &&
         rsp_tdata[CYCLE_BITS+PERIOD_BITS-1:CYCLE_BITS] != '0)
      else $error("zero cycle on accepted period");

   // overflow flag implies a saturated major cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> &rsp_tdata[CYCLE_BITS-1:0])
      else $error("overflow without saturated major cycle");

endmodule

bind cyclic_executive_cycle_calc cecc_checker #(
   .PERIOD_BITS (PERIOD_BITS),
   .CYCLE_BITS  (CYCLE_BITS)
) u_cecc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== bench/cyclic_executive_cycle_calc_tb.sv =====
module cyclic_executive_cycle_calc_tb;

   localparam int P_BITS = cecc_pkg::PERIOD_BITS_DEF;
   localparam int C_BITS = cecc_pkg::CYCLE_BITS_DEF;
   localparam int REQ_W  = ((P_BITS + 7) / 8) * 8;
   localparam int RSP_W  = ((C_BITS + P_BITS + 7) / 8) * 8;

   localparam longint unsigned CYCLE_MAX  = 64'({C_BITS{1'b1}});
   localparam longint unsigned PERIOD_MAX = 64'({P_BITS{1'b1}});

   // Status codes carried back in rsp_tuser
   localparam bit ST_ACCEPTED = 1'b0;
   localparam bit ST_ZERO_REJ = 1'b1;

   localparam int N_ITEMS     = 1050;
   localparam int PAUSE_AT    = 600;   // sender drains the block at this item
   localparam int HOLD_AT     = 300;   // receiver holds off after this response
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_WAIT  = 250;   // beyond the slowest single period

   typedef struct {
      bit [C_BITS-1:0] major;
      bit [P_BITS-1:0] minor;
      bit              ovf;
      bit              status;
   } cycle_result_type;

   // Running major/minor cycle predictor plus the store of pending results
   class cycle_board_type;
      bit [C_BITS-1:0]  run_lcm;
      bit [P_BITS-1:0]  run_gcd;
      bit               lcm_sat;
      bit               set_open;
      cycle_result_type expected_cycles[$];
      int               n_noted, n_checked, n_errors, n_sets, n_zero, n_sat;

      function longint unsigned euclid(longint unsigned x, longint unsigned y);
         longint unsigned r;
         while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
         end
         return x;
      endfunction

      function void note_period(bit [P_BITS-1:0] period, bit first);
         cycle_result_type res;
         longint unsigned  p, a, lg, q;
         p = 64'(period);
         res.status = ST_ACCEPTED;
         if (p == 0) begin
            res.status = ST_ZERO_REJ;
            n_zero++;
         end else if (first || !set_open) begin
            set_open = 1'b1;
            run_gcd  = P_BITS'(p);
            n_sets++;
            if (p > CYCLE_MAX) begin
               run_lcm = C_BITS'(CYCLE_MAX);
               lcm_sat = 1'b1;
               n_sat++;
            end else begin
               run_lcm = C_BITS'(p);
               lcm_sat = 1'b0;
            end
         end else begin
            run_gcd = P_BITS'(euclid(64'(run_gcd), p) & PERIOD_MAX);
            if (!lcm_sat) begin
               a  = 64'(run_lcm);
               lg = euclid(a, p);
               q  = (lg != 0) ? p / lg : p;
               if (a != 0 && q > CYCLE_MAX / a) begin
                  run_lcm = C_BITS'(CYCLE_MAX);
                  lcm_sat = 1'b1;
                  n_sat++;
               end else begin
                  run_lcm = C_BITS'((a * q) & CYCLE_MAX);
               end
            end
         end
         res.major  = run_lcm;
         res.minor  = run_gcd;
         res.ovf    = lcm_sat;
         expected_cycles.insert(expected_cycles.size(), res);
         n_noted++;
      endfunction

      function void check_response(bit [RSP_W-1:0] data, bit [1:0] user);
         cycle_result_type exp_r;
         bit [C_BITS-1:0]  major;
         bit [P_BITS-1:0]  minor;
         major = data[C_BITS-1:0];
         minor = data[C_BITS+P_BITS-1:C_BITS];
         n_checked++;
         if (expected_cycles.size() == 0) begin
            $error("response with nothing expected: major %0d minor %0d", major, minor);
            n_errors++;
            return;
         end
         exp_r = expected_cycles.pop_front();
         if (major !== exp_r.major) begin
            $error("major_cycle: expected %0d, got %0d", exp_r.major, major);
            n_errors++;
         end
         if (minor !== exp_r.minor) begin
            $error("minor_cycle: expected %0d, got %0d", exp_r.minor, minor);
            n_errors++;
         end
         if (user[0] !== exp_r.ovf) begin
            $error("overflow: expected %0d, got %0d", exp_r.ovf, user[0]);
            n_errors++;
         end
         if (user[1] !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, user[1]);
            n_errors++;
         end
      endfunction

      function int pending();
         return expected_cycles.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;    // period
   logic [0:0]       req_tuser;    // first_task
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;    // major_cycle, minor_cycle, zero padding
   logic [1:0]       rsp_tuser;    // overflow, status

   cycle_board_type board = new();

   int burst_left;
   int n_sent;
   bit long_hold_seen;

   cyclic_executive_cycle_calc u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Offer one period and hold it until the block takes the transaction.
   // Called at a rising edge; returns at the edge of acceptance.
   task automatic offer_period(bit [P_BITS-1:0] period, bit first);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(period);
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      board.note_period(period, first);
      n_sent++;
   endtask

   // Send one item inside the current burst; at the end of a burst drop
   // valid for a random gap (sometimes none) and draw the next burst length.
   task automatic send_period(bit [P_BITS-1:0] period, bit first);
      int gap;
      offer_period(period, first);
      burst_left--;
      if (burst_left <= 0) begin
         // mostly short bursts, now and then a long unbroken stretch
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Draw one period according to the flavour of the current task set
   function automatic bit [P_BITS-1:0] draw_period(int flavour, int base);
      if ($urandom_range(0, 15) == 0) return '0;              // zero period
      case (flavour)
         0: return P_BITS'(base * $urandom_range(1, 40));     // shared factors
         1: return P_BITS'($urandom_range(1, 32'(PERIOD_MAX))); // anywhere
         2: return P_BITS'(PERIOD_MAX - $urandom_range(0, 300)); // near the top
         default: return P_BITS'(1) << $urandom_range(0, P_BITS - 1);
      endcase
   endfunction

   // Receiver: stall on its own pattern, chosen from four modes at random,
   // and once hold off for a long stretch so that the block backs up.
   initial begin
      int  cyc;
      int  mode;
      int  hold_left;
      bit  ready_next;
      cyc       = 0;
      mode      = 0;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            board.check_response(rsp_tdata, rsp_tuser);
            if (board.n_checked == HOLD_AT) begin
               hold_left      = HOLD_CYCLES;
               long_hold_seen = 1'b1;
            end
         end
         cyc++;
         if (cyc % 50 == 0) mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            case (mode)
               0:       ready_next = 1'b1;
               1:       ready_next = 1'($urandom_range(0, 1));
               2:       ready_next = (cyc % 4 == 0);
               default: ready_next = ($urandom_range(0, 9) != 0);
            endcase
         end
         rsp_tready <= ready_next;
      end
   end

   // Stimulus and end of run
   initial begin
      int set_len;
      int flavour;
      int base;
      bit first;
      bit paused;

      n_sent         = 0;
      burst_left     = 5;
      paused         = 1'b0;
      long_hold_seen = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero period before any set, with and without the start mark
      send_period(0, 0);
      send_period(0, 1);
      // continuation before any set opens one
      send_period(12, 0);
      send_period(18, 0);
      send_period(0, 0);        // zero mid-set leaves the state alone
      send_period(30, 0);
      send_period(0, 1);        // zero with start mark must not reopen the set
      // field extremes
      send_period(P_BITS'(PERIOD_MAX), 1);
      send_period(1, 0);
      send_period(16'h8000, 1);
      send_period(16'h4000, 0);
      send_period(P_BITS'(PERIOD_MAX), 0);
      send_period(1, 1);
      send_period(1, 0);
      // large primes: drive the major cycle into saturation
      send_period(65521, 1);
      send_period(65519, 0);
      send_period(65497, 0);
      send_period(P_BITS'(PERIOD_MAX), 0); // saturated, minor cycle still updated
      send_period(0, 0);
      send_period(2, 0);
      // new set clears the overflow flag
      send_period(7, 1);
      send_period(P_BITS'(PERIOD_MAX), 0);
      send_period(65534, 0);
      send_period(32767, 0);

      // Random task sets: mostly well formed, with stray start marks and zeros
      while (n_sent < N_ITEMS) begin
         set_len = $urandom_range(1, 7);
         flavour = $urandom_range(0, 3);
         base    = $urandom_range(1, 60);
         for (int i = 0; i < set_len && n_sent < N_ITEMS; i++) begin
            first = (i == 0);
            if ($urandom_range(0, 19) == 0) first = ~first;
            if ($urandom_range(0, 9) == 0)
               send_period(P_BITS'($urandom), first);   // noise
            else
               send_period(draw_period(flavour, base), first);
            // once, let the block drain completely before going on
            if (!paused && n_sent >= PAUSE_AT) begin
               paused = 1'b1;
               req_tvalid <= 1'b0;
               while (board.pending() != 0) @(posedge clock);
            end
         end
      end

      // Drain: wait for every result, then a little longer for strays
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Covered %0d periods in %0d task sets: %0d zero rejects, %0d saturations.",
               n_sent, board.n_sets, board.n_zero, board.n_sat);
      $display("Checked %0d responses; long receiver hold %s, one full drain mid-run.",
               board.n_checked, long_hold_seen ? "done" : "missed");
      if (board.n_errors == 0 && board.pending() == 0) begin
         $display("[cyclic_executive_cycle_calc] OK");
      end else begin
         $display("[cyclic_executive_cycle_calc] ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #15_000_000;
      $display("[cyclic_executive_cycle_calc] ERROR");
      $finish;
   end

endmodule
